// ===== rtl/fqbb_pkg.sv =====
// Package for the frame queue with byte budget.
// Holds action and status codes, register indexes, widths and the
// controller-to-datapath command and status types. No dependencies.
`timescale 1ns / 1ps

package fqbb_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int LENGTH_BITS_DEF = 16;

	localparam int ACTION_BITS = 2;
	localparam int STATUS_BITS = 3;
	localparam int BYTES_BITS = 22;
	localparam int CFG_INDEX_BITS = 2;

	localparam logic [BYTES_BITS-1:0] BYTE_LIMIT_RST = 22'h200000;

	localparam logic [ACTION_BITS-1:0] ACT_TRANSMIT = 2'd0;
	localparam logic [ACTION_BITS-1:0] ACT_DRAIN = 2'd1;
	localparam logic [ACTION_BITS-1:0] ACT_OPEN = 2'd2;
	localparam logic [ACTION_BITS-1:0] ACT_STOP = 2'd3;

	localparam logic [STATUS_BITS-1:0] ST_OK = 3'd0;
	localparam logic [STATUS_BITS-1:0] ST_NODEV = 3'd1;
	localparam logic [STATUS_BITS-1:0] ST_DOWN = 3'd2;
	localparam logic [STATUS_BITS-1:0] ST_NOBUFS = 3'd3;
	localparam logic [STATUS_BITS-1:0] ST_EMPTY = 3'd4;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_DEVICE_READY = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_BYTE_LIMIT = 2'd1;

	typedef struct packed {
		logic accept;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic drain_hit;
	} dp_stat_t;

endpackage

// ===== rtl/frame_queue_with_byte_budget.sv =====
// Top level of the frame queue with byte budget.
// Joins fqbb_ctrl and fqbb_dp and packs the stream words; uses fqbb_pkg.
`timescale 1ns / 1ps

// A queue of frame handles and lengths, limited by entry count and by the
// total of queued bytes. Each input word on the s_ channel carries an action
// in s_tuser (transmit, drain, open, stop) and a frame in s_tdata. Each input
// word produces exactly one result word on the m_ channel, with the status in
// m_tuser and the dequeued frame, flush count and occupancy in m_tdata.
// The cfg channel writes the device-ready flag and the byte limit; it is
// always ready and should only be used while no word is in flight.
// Words are handled one at a time. A result appears in the cycle after the
// input word is taken, or, for a successful drain, after the extra S_READ
// state that copies the registered read of the entry memory. The next input
// word is taken in the cycle after the result is taken. While the receiver
// holds m_tready low the result stays put and s_tready stays low.
// Reset empties the queue, enables it, clears device-ready and sets the byte
// limit to 2 MiB; the entry memories are not cleared.
module frame_queue_with_byte_budget #(
	parameter int QUEUE_DEPTH = fqbb_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = fqbb_pkg::HANDLE_BITS_DEF,
	parameter int LENGTH_BITS = fqbb_pkg::LENGTH_BITS_DEF,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
	localparam int S_W = ((LENGTH_BITS + HANDLE_BITS + 7) / 8) * 8,
	localparam int M_W = ((HANDLE_BITS + LENGTH_BITS + 2 * CNT_W + 7) / 8) * 8
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// frame_length, frame_handle
	input  logic [S_W-1:0]                      s_tdata,
	// action
	input  logic [fqbb_pkg::ACTION_BITS-1:0]    s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// out_handle, out_length, flushed_count, occupancy
	output logic [M_W-1:0]                      m_tdata,
	// status
	output logic [fqbb_pkg::STATUS_BITS-1:0]    m_tuser,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fqbb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [fqbb_pkg::BYTES_BITS-1:0]     cfg_data
);
	import fqbb_pkg::*;

	localparam int PAD_W = M_W - (HANDLE_BITS + LENGTH_BITS + 2 * CNT_W);

	cmd_t                 cmd;
	dp_stat_t             stat;
	logic [HANDLE_BITS-1:0] out_handle;
	logic [LENGTH_BITS-1:0] out_length;
	logic [CNT_W-1:0]       flushed_count;
	logic [CNT_W-1:0]       occupancy;

	assign cfg_ready = 1'b1;

	fqbb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fqbb_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HANDLE_BITS (HANDLE_BITS),
		.LENGTH_BITS (LENGTH_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.action        (s_tuser),
		.frame_length  (s_tdata[LENGTH_BITS-1:0]),
		.frame_handle  (s_tdata[LENGTH_BITS +: HANDLE_BITS]),
		.cfg_write     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.status        (m_tuser),
		.out_handle    (out_handle),
		.out_length    (out_length),
		.flushed_count (flushed_count),
		.occupancy     (occupancy)
	);

	assign m_tdata = {{PAD_W{1'b0}}, occupancy, flushed_count, out_length, out_handle};

`ifndef SYNTH
	a_one_word_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input accepted while a result is pending");

	a_accept_blocks_next: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second word accepted before the first result");

	a_flush_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (flushed_count != '0)) |-> (occupancy == '0))
		else $error("flush result reports a nonempty queue");

	a_occupancy_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (occupancy <= CNT_W'(QUEUE_DEPTH)))
		else $error("occupancy above queue depth");
`endif

endmodule

// ===== rtl/fqbb_ctrl.sv =====
// Controller state machine for the frame queue with byte budget.
// Sequences accept, memory read and result hand-off; uses fqbb_pkg.
`timescale 1ns / 1ps

module fqbb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  fqbb_pkg::dp_stat_t stat,
	output fqbb_pkg::cmd_t     cmd
);
	import fqbb_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_RESP);
	assign cmd.accept = s_tvalid && s_tready;
	assign cmd.pop = (state_q == S_READ);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					state_d = stat.drain_hit ? S_READ : S_RESP;
				end
			end
			S_READ: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				if (m_tready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/fqbb_dp.sv =====
// Datapath for the frame queue with byte budget: entry memories, pointers,
// counters, configuration registers and the result register; uses fqbb_pkg.
`timescale 1ns / 1ps

module fqbb_dp #(
	parameter int QUEUE_DEPTH = fqbb_pkg::QUEUE_DEPTH_DEF,
	parameter int HANDLE_BITS = fqbb_pkg::HANDLE_BITS_DEF,
	parameter int LENGTH_BITS = fqbb_pkg::LENGTH_BITS_DEF,
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fqbb_pkg::cmd_t                         cmd,
	output fqbb_pkg::dp_stat_t                     stat,
	input  logic [fqbb_pkg::ACTION_BITS-1:0]       action,
	input  logic [LENGTH_BITS-1:0]                 frame_length,
	input  logic [HANDLE_BITS-1:0]                 frame_handle,
	input  logic                                  cfg_write,
	input  logic [fqbb_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  logic [fqbb_pkg::BYTES_BITS-1:0]        cfg_data,
	output logic [fqbb_pkg::STATUS_BITS-1:0]       status,
	output logic [HANDLE_BITS-1:0]                 out_handle,
	output logic [LENGTH_BITS-1:0]                 out_length,
	output logic [CNT_W-1:0]                       flushed_count,
	output logic [CNT_W-1:0]                       occupancy
);
	import fqbb_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CMP_W = (LENGTH_BITS > BYTES_BITS) ? LENGTH_BITS : BYTES_BITS;

	logic [HANDLE_BITS-1:0] handle_mem [QUEUE_DEPTH];
	logic [LENGTH_BITS-1:0] length_mem [QUEUE_DEPTH];
	logic [HANDLE_BITS-1:0] rd_handle_q;
	logic [LENGTH_BITS-1:0] rd_length_q;

	logic [PTR_W-1:0]      rd_ptr_q;
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [CNT_W-1:0]      count_q;
	logic [BYTES_BITS-1:0] bytes_q;
	logic                  enabled_q;
	logic                  dev_ready_q;
	logic [BYTES_BITS-1:0] byte_limit_q;

	logic [STATUS_BITS-1:0] status_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [LENGTH_BITS-1:0] out_length_q;
	logic [CNT_W-1:0]       flushed_q;
	logic [CNT_W-1:0]       occ_q;

	logic [BYTES_BITS-1:0] room;
	logic                  full;
	logic                  too_long;
	logic                  admit;
	logic [PTR_W-1:0]      wr_ptr_next;
	logic [PTR_W-1:0]      rd_ptr_next;
	logic                  pop_covers;

	assign room = (byte_limit_q > bytes_q) ? byte_limit_q - bytes_q : '0;
	assign full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign too_long = (CMP_W'(frame_length) > CMP_W'(room));
	assign admit = cmd.accept && (action == ACT_TRANSMIT) && dev_ready_q && enabled_q
		&& !full && !too_long;
	assign wr_ptr_next = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_next = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
	assign pop_covers = (CMP_W'(bytes_q) >= CMP_W'(rd_length_q));

	assign stat.drain_hit = (action == ACT_DRAIN) && (count_q != '0);

	assign status = status_q;
	assign out_handle = out_handle_q;
	assign out_length = out_length_q;
	assign flushed_count = flushed_q;
	assign occupancy = occ_q;

	// The read port follows the read pointer through a register, so the head entry
	// is ready when the pop that follows an accepted drain copies it.
	always_ff @(posedge clk) begin
		if (admit) begin
			handle_mem[wr_ptr_q] <= frame_handle;
			length_mem[wr_ptr_q] <= frame_length;
		end
		rd_handle_q <= handle_mem[rd_ptr_q];
		rd_length_q <= length_mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_ready_q <= 1'b0;
			byte_limit_q <= BYTE_LIMIT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_DEVICE_READY: dev_ready_q <= cfg_data[0];
				CFG_BYTE_LIMIT: byte_limit_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q <= '0;
			bytes_q <= '0;
			enabled_q <= 1'b1;
		end else if (cmd.accept) begin
			case (action)
				ACT_TRANSMIT: begin
					if (admit) begin
						wr_ptr_q <= wr_ptr_next;
						count_q <= count_q + 1'b1;
						bytes_q <= bytes_q + BYTES_BITS'(frame_length);
					end
				end
				ACT_OPEN: begin
					if (dev_ready_q) begin
						enabled_q <= 1'b1;
					end
				end
				ACT_STOP: begin
					enabled_q <= 1'b0;
					rd_ptr_q <= wr_ptr_q;
					count_q <= '0;
					bytes_q <= '0;
				end
				default: begin
				end
			endcase
		end else if (cmd.pop) begin
			rd_ptr_q <= rd_ptr_next;
			count_q <= count_q - 1'b1;
			bytes_q <= pop_covers ? bytes_q - BYTES_BITS'(rd_length_q) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			status_q <= ST_OK;
			out_handle_q <= '0;
			out_length_q <= '0;
			flushed_q <= '0;
			occ_q <= count_q;
			case (action)
				ACT_TRANSMIT: begin
					if (!dev_ready_q || !enabled_q) begin
						status_q <= ST_DOWN;
					end else if (full || too_long) begin
						status_q <= ST_NOBUFS;
					end else begin
						occ_q <= count_q + 1'b1;
					end
				end
				ACT_DRAIN: begin
					if (count_q == '0) begin
						status_q <= ST_EMPTY;
					end
				end
				ACT_OPEN: begin
					if (!dev_ready_q) begin
						status_q <= ST_NODEV;
					end
				end
				default: begin
					flushed_q <= count_q;
					occ_q <= '0;
				end
			endcase
		end else if (cmd.pop) begin
			out_handle_q <= rd_handle_q;
			out_length_q <= rd_length_q;
			occ_q <= count_q - 1'b1;
		end
	end

endmodule
